// ===== hdl/ifms_pkg.sv =====
// ----------------------------------------------------------------------------
// ifms_pkg: shared types and constants for the image format magic sniffer
// Request/response payloads, status codes, FourCC codes and signature table.
// ----------------------------------------------------------------------------
package ifms_pkg;

   localparam int SIG_COUNT   = 9;
   localparam int PREFIX_LEN  = 16;
   localparam int TAIL_MAX    = 3;

   // status codes
   localparam logic [1:0] ST_RECOGNIZED = 2'd0;
   localparam logic [1:0] ST_UNKNOWN    = 2'd1;
   localparam logic [1:0] ST_NEED_MORE  = 2'd2;

   // FourCC codes
   localparam logic [31:0] FCC_RIFF = 32'h52494646;
   localparam logic [31:0] FCC_WEBP = 32'h57454250;
   localparam logic [31:0] FCC_VP8  = 32'h56503820;
   localparam logic [31:0] FCC_VP8L = 32'h5650384C;
   localparam logic [31:0] FCC_WP8  = 32'h57503820;
   localparam logic [31:0] FCC_WP8L = 32'h5750384C;
   localparam logic [31:0] FCC_PNG  = 32'h504E4720;
   localparam logic [31:0] FCC_JPEG = 32'h4A504547;
   localparam logic [31:0] FCC_GIF  = 32'h47494620;
   localparam logic [31:0] FCC_TIFF = 32'h54494646;
   localparam logic [31:0] FCC_BMP  = 32'h424D5020;
   localparam logic [31:0] FCC_WBMP = 32'h57424D50;
   localparam logic [31:0] FCC_NIE  = 32'h4E494520;

   typedef struct packed {
      logic [63:0] bytes_low;
      logic [63:0] bytes_high;
      logic [4:0]  valid_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] fourcc;
   } rsp_type;

   typedef struct packed {
      logic [7:0]                 lead;
      logic [1:0]                 tail_len;
      logic [TAIL_MAX-1:0][7:0]   tail;      // tail[0] is the second byte
      logic [31:0]                code;
   } sig_entry_type;

   localparam sig_entry_type SIG_TABLE [SIG_COUNT] = '{
      '{lead: 8'h00, tail_len: 2'd1, tail: {8'h00, 8'h00, 8'h00}, code: FCC_WBMP},
      '{lead: 8'h42, tail_len: 2'd1, tail: {8'h00, 8'h00, 8'h4D}, code: FCC_BMP},
      '{lead: 8'h47, tail_len: 2'd3, tail: {8'h38, 8'h46, 8'h49}, code: FCC_GIF},
      '{lead: 8'h49, tail_len: 2'd3, tail: {8'h00, 8'h2A, 8'h49}, code: FCC_TIFF},
      '{lead: 8'h4D, tail_len: 2'd3, tail: {8'h2A, 8'h00, 8'h4D}, code: FCC_TIFF},
      '{lead: 8'h52, tail_len: 2'd3, tail: {8'h46, 8'h46, 8'h49}, code: FCC_RIFF},
      '{lead: 8'h6E, tail_len: 2'd2, tail: {8'h00, 8'hAF, 8'hC3}, code: FCC_NIE},
      '{lead: 8'h89, tail_len: 2'd3, tail: {8'h47, 8'h4E, 8'h50}, code: FCC_PNG},
      '{lead: 8'hFF, tail_len: 2'd1, tail: {8'h00, 8'h00, 8'hD8}, code: FCC_JPEG}
   };

endpackage

// ===== hdl/ifms_classify.sv =====
// ----------------------------------------------------------------------------
// ifms_classify: signature compare logic
// Classifies one 16-byte prefix against the signature table, no state.
// ----------------------------------------------------------------------------
module ifms_classify
   import ifms_pkg::*;
(
   input  req_type prefix,
   output rsp_type result
);

   logic [PREFIX_LEN-1:0][7:0] pbyte;
   logic [4:0]                 count;
   logic [31:0]                word_mid;
   logic [31:0]                word_end;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         pbyte[k]     = prefix.bytes_low[8*k +: 8];
         pbyte[k + 8] = prefix.bytes_high[8*k +: 8];
      end
   end

   // saturate counts above sixteen
   assign count    = (prefix.valid_count > 5'd16) ? 5'd16 : prefix.valid_count;
   assign word_mid = {pbyte[8], pbyte[9], pbyte[10], pbyte[11]};
   assign word_end = {pbyte[12], pbyte[13], pbyte[14], pbyte[15]};

   always_comb begin
      logic       same;
      logic [4:0] avail;
      logic [1:0] status;
      logic [31:0] code;
      same   = 1'b1;
      avail  = count - 5'd1;
      status = ST_UNKNOWN;
      code   = '0;
      if (count == 5'd0) begin
         status = ST_NEED_MORE;
      end else begin
         // leads are distinct, so at most one entry hits
         for (int i = 0; i < SIG_COUNT; i++) begin
            if (SIG_TABLE[i].lead == pbyte[0]) begin
               same = 1'b1;
               for (int k = 0; k < TAIL_MAX; k++) begin
                  if ((2'(k) < SIG_TABLE[i].tail_len) && (5'(k) < avail) &&
                      (pbyte[k + 1] != SIG_TABLE[i].tail[k])) begin
                     same = 1'b0;
                  end
               end
               if (!same) begin
                  status = ST_UNKNOWN;
               end else if (avail < {3'd0, SIG_TABLE[i].tail_len}) begin
                  status = ST_NEED_MORE;
               end else if (SIG_TABLE[i].code == FCC_RIFF) begin
                  if (count < 5'd16) begin
                     status = ST_NEED_MORE;
                  end else begin
                     status = ST_RECOGNIZED;
                     code   = FCC_RIFF;
                     if (word_mid == FCC_WEBP) begin
                        if (word_end == FCC_VP8) begin
                           code = FCC_WP8;
                        end else if (word_end == FCC_VP8L) begin
                           code = FCC_WP8L;
                        end
                     end
                  end
               end else begin
                  status = ST_RECOGNIZED;
                  code   = SIG_TABLE[i].code;
               end
            end
         end
      end
      result.status = status;
      result.fourcc = (status == ST_RECOGNIZED) ? code : 32'd0;
   end

endmodule

// ===== hdl/image_format_magic_sniffer.sv =====
// ----------------------------------------------------------------------------
// image_format_magic_sniffer: image file type detection from magic bytes
// Registered request stage, signature compare, registered response stage.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one request carries the first 16 bytes of a file (bytes_low,
//            bytes_high) and the count of valid bytes (saturated at 16).
//   rsp_*  : one response per request: status (recognized / unknown /
//            need more bytes) and the big-endian FourCC, zero unless
//            recognized.
//   A transfer happens on a rising clock edge with valid high, stall low.
// Timing
//   A request taken into the request register drives the compare logic,
//   which loads the response register (rsp_valid rises) once that register
//   is empty or being taken; the response then waits there until taken.
//   Throughput is one request per cycle while rsp_stall is low; the path is
//   a single compare against the nine fixed signatures.
// Reset
//   Synchronous, active high; clears both stage valid flags. Payload registers are not reset.
// Backpressure
//   While rsp_stall holds a response, the request stage still takes one more
//   request; req_stall rises only when both stages are full and the response
//   cannot move.
// ----------------------------------------------------------------------------
module image_format_magic_sniffer
   import ifms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // request stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   // response stage
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_data_ff;

   rsp_type cls_result;
   logic    s2_load;
   logic    s1_load;

   // response register frees up when empty or being taken
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   // request register frees up when empty or moving forward
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_load   = req_valid && !req_stall;

   assign s1_valid_in = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   ifms_classify u_classify (
      .prefix (s1_data_ff),
      .result (cls_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
      if (s2_load && s1_valid_ff) begin
         s2_data_ff <= cls_result;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

endmodule

// ===== hdl/ifms_checker.sv =====
// ----------------------------------------------------------------------------
// ifms_checker: port-level checks for the magic sniffer
// Response consistency and handshake checks, bound to the top level.
// ----------------------------------------------------------------------------
module ifms_checker
   import ifms_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // fourcc is zero unless recognized, status code in range
   a_fourcc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_RECOGNIZED) |-> rsp_data.fourcc == 32'd0)
      else $error("fourcc set on unrecognized response");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_RECOGNIZED) ||
                    (rsp_data.status == ST_UNKNOWN) ||
                    (rsp_data.status == ST_NEED_MORE))
      else $error("bad status code");

   // stall toward the requester only while the response side is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without response backpressure");

endmodule

bind image_format_magic_sniffer ifms_checker u_checker (.*);
